FILE: hw/rtl/pulse_distance_remote_transmitter_defines.svh
// Assertion helpers
`ifndef PULSE_DISTANCE_REMOTE_TRANSMITTER_DEFINES_SVH
`define PULSE_DISTANCE_REMOTE_TRANSMITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PDRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PDRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PDRT_ASSERT_IMPL(label, ante, cons)
`define PDRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/pdrt_pkg.sv
`default_nettype none

package pdrt_pkg;

  localparam int unsigned FRAME_BITS = 17;

  localparam logic [6:0] DEVICE_CODE    = 7'h47;
  localparam logic [4:0] PRE_HIGH_UNITS = 5'd16;
  localparam logic [4:0] PRE_GAP_UNITS  = 5'd8;
  localparam logic [4:0] ONE_LOW_UNITS  = 5'd3;
  localparam logic [4:0] ONE_UNIT       = 5'd1;
  localparam logic [4:0] LAST_BIT       = 5'(FRAME_BITS - 1);

  localparam logic REG_UNIT_LEN     = 1'b0;
  localparam logic REG_REPEAT_COUNT = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_PRE_LOW  = 6'b000010,
    PH_PRE_HIGH = 6'b000100,
    PH_PRE_GAP  = 6'b001000,
    PH_BIT_HIGH = 6'b010000,
    PH_BIT_LOW  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [6:0] command;
  } item_t;

  typedef struct packed {
    logic rejected;
    logic done_res;
    logic busy_res;
    logic line_level;
  } result_t;

  typedef struct packed {
    logic busy;
    logic level;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pulse_distance_remote_transmitter.sv
// Pulse-distance remote-control transmitter. A transfer with s_tuser = 1 loads a 7-bit command
// and starts a burst of repeat_count frames; a transfer with s_tuser = 0 is one time tick.
// Each frame is a preamble (low 1 unit, high 16, low 8) then 17 bits (start 1, device code
// 0x47, command, two stop 1s, LSB first), a bit being high 1 unit then low 1 unit (0) or 3
// units (1); one unit is unit_len ticks, 0 counting as 1. Every input transfer yields one
// output transfer with the line level after that item and busy, done and rejected flags; a
// load while busy is ignored and flagged. One item is taken per clock while the output is not
// stalled (m_tvalid high and m_tready low): an input register and an output register surround
// the tick counter and segment update. Registers: unit_len at 0x0, repeat_count at 0x4; write
// them only while no transfer is in flight.
`default_nettype none
`include "pulse_distance_remote_transmitter_defines.svh"

module pulse_distance_remote_transmitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [6:0] command, [7] zero
  input  wire logic        s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] line_level, [1] busy_res, [2] done_res,
                                      // [3] rejected, [7:4] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pdrt_pkg::*;

  logic [15:0] unit_len;
  logic [3:0]  repeat_count;

  logic        in_valid;
  item_t       item_q;
  logic        out_valid;
  result_t     res_q;
  logic        advance;
  logic        item_en;
  result_t     result;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_len     <= 16'd527;
      repeat_count <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_UNIT_LEN:     unit_len     <= pwdata[15:0];
        REG_REPEAT_COUNT: repeat_count <= pwdata[3:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      unique case (paddr[2])
        REG_UNIT_LEN:     prdata = {16'd0, unit_len};
        REG_REPEAT_COUNT: prdata = {28'd0, repeat_count};
        default:          prdata = 32'd0;
      endcase
    end
  end

  assign advance  = !out_valid || m_tready;
  assign item_en  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      item_q.func    <= s_tuser;
      item_q.command <= s_tdata[6:0];
    end
  end

  pdrt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_en      (item_en),
    .item         (item_q),
    .unit_len     (unit_len),
    .repeat_count (repeat_count),
    .result       (result),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_en;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      res_q <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, res_q.rejected, res_q.done_res, res_q.busy_res, res_q.line_level};

  `PDRT_ASSERT_IMPL(a_idle_line_low, !status.busy, !status.level)
  `PDRT_ASSERT_NEXT(a_busy_load_rejected, item_en && item_q.func && status.busy, m_tvalid && m_tdata[3])
  `PDRT_ASSERT_IMPL(a_stall_from_output, !s_tready, m_tvalid && !m_tready)
  `PDRT_ASSERT_IMPL(a_done_not_busy, m_tvalid && m_tdata[2], !m_tdata[1])

endmodule

`default_nettype wire

FILE: hw/rtl/pdrt_seq.sv
`default_nettype none

module pdrt_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_en,
  input  wire pdrt_pkg::item_t  item,
  input  wire logic [15:0]      unit_len,
  input  wire logic [3:0]       repeat_count,
  output pdrt_pkg::result_t     result,
  output pdrt_pkg::status_t     status
);
  import pdrt_pkg::*;

  phase_t      phase, phase_next;
  logic        level, level_next;
  logic [15:0] tick_count, tick_count_next;
  logic [4:0]  units_left, units_left_next;
  logic [4:0]  bit_index, bit_index_next;
  logic [16:0] frame_bits, frame_bits_next;
  logic [3:0]  repeats_left, repeats_left_next;

  logic [15:0] len_eff;
  logic [16:0] tick_inc;
  logic [4:0]  units_dec;
  logic [3:0]  repeats_dec;
  logic        done;
  logic        rej;

  always_comb begin
    phase_next        = phase;
    level_next        = level;
    tick_count_next   = tick_count;
    units_left_next   = units_left;
    bit_index_next    = bit_index;
    frame_bits_next   = frame_bits;
    repeats_left_next = repeats_left;
    done              = 1'b0;
    rej               = 1'b0;
    len_eff           = (unit_len == 16'd0) ? 16'd1 : unit_len;
    tick_inc          = {1'b0, tick_count} + 17'd1;
    units_dec         = units_left - 5'd1;
    repeats_dec       = repeats_left - 4'd1;

    if (item.func) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else if (repeat_count == 4'd0) begin
        done       = 1'b1;
        level_next = 1'b0;
      end else begin
        frame_bits_next   = {2'b11, item.command, DEVICE_CODE, 1'b1};
        repeats_left_next = repeat_count;
        bit_index_next    = 5'd0;
        phase_next        = PH_PRE_LOW;
        level_next        = 1'b0;
        units_left_next   = ONE_UNIT;
        tick_count_next   = 16'd0;
      end
    end else if (phase != PH_IDLE) begin
      if (tick_inc >= {1'b0, len_eff}) begin
        tick_count_next = 16'd0;
        units_left_next = units_dec;
        if (units_dec == 5'd0) begin
          unique case (phase)
            PH_PRE_LOW: begin
              phase_next      = PH_PRE_HIGH;
              level_next      = 1'b1;
              units_left_next = PRE_HIGH_UNITS;
            end
            PH_PRE_HIGH: begin
              phase_next      = PH_PRE_GAP;
              level_next      = 1'b0;
              units_left_next = PRE_GAP_UNITS;
            end
            PH_PRE_GAP: begin
              bit_index_next  = 5'd0;
              phase_next      = PH_BIT_HIGH;
              level_next      = 1'b1;
              units_left_next = ONE_UNIT;
            end
            PH_BIT_HIGH: begin
              phase_next      = PH_BIT_LOW;
              level_next      = 1'b0;
              units_left_next = frame_bits[bit_index] ? ONE_LOW_UNITS : ONE_UNIT;
            end
            PH_BIT_LOW: begin
              if (bit_index != LAST_BIT) begin
                bit_index_next  = bit_index + 5'd1;
                phase_next      = PH_BIT_HIGH;
                level_next      = 1'b1;
                units_left_next = ONE_UNIT;
              end else begin
                repeats_left_next = repeats_dec;
                if (repeats_dec != 4'd0) begin
                  phase_next      = PH_PRE_LOW;
                  level_next      = 1'b0;
                  units_left_next = ONE_UNIT;
                end else begin
                  phase_next      = PH_IDLE;
                  level_next      = 1'b0;
                  units_left_next = 5'd0;
                  bit_index_next  = 5'd0;
                  done            = 1'b1;
                end
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              level_next      = 1'b0;
              units_left_next = 5'd0;
            end
          endcase
        end
      end else begin
        tick_count_next = tick_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      level        <= 1'b0;
      tick_count   <= 16'd0;
      units_left   <= 5'd0;
      bit_index    <= 5'd0;
      frame_bits   <= 17'd0;
      repeats_left <= 4'd0;
    end else if (item_en) begin
      phase        <= phase_next;
      level        <= level_next;
      tick_count   <= tick_count_next;
      units_left   <= units_left_next;
      bit_index    <= bit_index_next;
      frame_bits   <= frame_bits_next;
      repeats_left <= repeats_left_next;
    end
  end

  assign result.line_level = level_next;
  assign result.busy_res   = (phase_next != PH_IDLE);
  assign result.done_res   = done;
  assign result.rejected   = rej;

  assign status.busy  = (phase != PH_IDLE);
  assign status.level = level;

endmodule

`default_nettype wire
